>>> hdl/gaps_pkg.sv
// ----------------------------------------------------------------------------
// gaps_pkg: shared types and constants for the grid path search core
// Grid geometry, cost constants, node record, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package gaps_pkg;

    localparam int GRID_WIDTH  = 8;
    localparam int GRID_HEIGHT = 8;
    localparam int NCELLS      = GRID_WIDTH * GRID_HEIGHT;
    localparam int X_W         = $clog2(GRID_WIDTH);
    localparam int Y_W         = $clog2(GRID_HEIGHT);
    localparam int D_W         = (X_W > Y_W) ? X_W : Y_W;
    localparam int CELL_W      = $clog2(NCELLS);
    localparam int CNT_W       = $clog2(NCELLS + 1);
    localparam int COST_W      = 14;
    localparam int F_W         = COST_W + 1;
    localparam int IO_W        = 3;
    localparam int MAX_OUT     = 64;
    localparam int OUT_CNT_W   = $clog2(MAX_OUT);
    localparam int NDIRS       = 8;
    localparam int DIR_W       = $clog2(NDIRS);

    localparam logic [COST_W-1:0] COST_STRAIGHT  = 14'd10;
    localparam logic [COST_W-1:0] COST_DIAG      = 14'd14;
    localparam logic [COST_W-1:0] COST_UNREACHED = 14'd9999;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_FIND  = 1'b1;

    // per-axis move codes
    localparam logic [1:0] MV_ZERO  = 2'd0;
    localparam logic [1:0] MV_MINUS = 2'd1;
    localparam logic [1:0] MV_PLUS  = 2'd2;

    // neighbor visiting order
    localparam logic [1:0] NDX [NDIRS] = '{MV_MINUS, MV_MINUS, MV_MINUS, MV_PLUS,
                                           MV_PLUS, MV_PLUS, MV_ZERO, MV_ZERO};
    localparam logic [1:0] NDY [NDIRS] = '{MV_ZERO, MV_PLUS, MV_MINUS, MV_ZERO,
                                           MV_MINUS, MV_PLUS, MV_MINUS, MV_PLUS};

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic [COST_W-1:0] heur;
        logic              par_none;
        logic [X_W-1:0]    par_x;
        logic [Y_W-1:0]    par_y;
        logic [CNT_W-1:0]  order;
    } node_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_SCAN_DONE,
        ST_NB_ADDR,
        ST_NB_EVAL,
        ST_PATH_RD,
        ST_PATH_LOAD,
        ST_FAIL_LOAD,
        ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        logic             in_ready;
        logic             init;
        logic             scan_rd;
        logic             scan_clear;
        logic             expand;
        logic [DIR_W-1:0] dir;
        logic             nb_rd;
        logic             mark_wall;
        logic             nb_eval;
        logic             path_start;
        logic             path_rd;
        logic             load_path;
        logic             cap;
        logic             load_fail;
    } cmd_t;

    typedef struct packed {
        logic req_find;
        logic req_ok;
        logic have_best;
        logic best_is_goal;
        logic nb_in_range;
        logic nb_closed;
        logic nb_wall;
        logic out_taken;
        logic out_last;
    } status_t;

    function automatic logic [CELL_W-1:0] cell_idx(input logic [X_W-1:0] x,
                                                   input logic [Y_W-1:0] y);
        logic [CELL_W-1:0] row;
        row = CELL_W'(y) * CELL_W'(GRID_WIDTH);
        return row + CELL_W'(x);
    endfunction

    // octile distance: 14 per diagonal, 10 per straight step
    function automatic logic [COST_W-1:0] octile(input logic [X_W-1:0] ax,
                                                 input logic [Y_W-1:0] ay,
                                                 input logic [X_W-1:0] bx,
                                                 input logic [Y_W-1:0] by);
        logic [D_W-1:0] dx;
        logic [D_W-1:0] dy;
        logic [D_W-1:0] mn;
        logic [D_W-1:0] rem;
        dx  = (ax > bx) ? D_W'(ax - bx) : D_W'(bx - ax);
        dy  = (ay > by) ? D_W'(ay - by) : D_W'(by - ay);
        mn  = (dx < dy) ? dx : dy;
        rem = (dx > dy) ? (dx - dy) : (dy - dx);
        return (COST_DIAG * COST_W'(mn)) + (COST_STRAIGHT * COST_W'(rem));
    endfunction

endpackage

>>> hdl/gaps_ctrl.sv
// ----------------------------------------------------------------------------
// gaps_ctrl: search sequencer
// Steps through accept, open-set scan, neighbor expansion and path emission.
// ----------------------------------------------------------------------------
module gaps_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    input  gaps_pkg::status_t sts,
    output gaps_pkg::cmd_t    cmd
);
    import gaps_pkg::*;

    state_t                 state_reg, state_next;
    logic [CELL_W-1:0]      idx_reg, idx_next;
    logic [DIR_W-1:0]       dir_reg, dir_next;
    logic [OUT_CNT_W-1:0]   cnt_reg, cnt_next;
    logic                   nb_usable;

    assign nb_usable = sts.nb_in_range && !sts.nb_closed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            dir_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            dir_reg   <= dir_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and counters
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        dir_next   = dir_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && sts.req_find)
                    state_next = sts.req_ok ? ST_INIT : ST_FAIL_LOAD;
            end
            ST_INIT:
            begin
                idx_next   = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CELL_W'(NCELLS - 1))
                    state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
                state_next = ST_SCAN_DONE;
            ST_SCAN_DONE:
            begin
                if (!sts.have_best)
                    state_next = ST_FAIL_LOAD;
                else if (sts.best_is_goal)
                begin
                    cnt_next   = '0;
                    state_next = ST_PATH_RD;
                end
                else
                begin
                    dir_next   = '0;
                    state_next = ST_NB_ADDR;
                end
            end
            ST_NB_ADDR:
            begin
                if (nb_usable && !sts.nb_wall)
                    state_next = ST_NB_EVAL;
                else
                begin
                    dir_next = dir_reg + 1'b1;
                    if (dir_reg == DIR_W'(NDIRS - 1))
                    begin
                        idx_next   = '0;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_NB_EVAL:
            begin
                dir_next = dir_reg + 1'b1;
                if (dir_reg == DIR_W'(NDIRS - 1))
                begin
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
                else
                    state_next = ST_NB_ADDR;
            end
            ST_PATH_RD:
                state_next = ST_PATH_LOAD;
            ST_PATH_LOAD:
                state_next = ST_OUT_WAIT;
            ST_FAIL_LOAD:
                state_next = ST_OUT_WAIT;
            ST_OUT_WAIT:
            begin
                if (sts.out_taken)
                begin
                    if (sts.out_last)
                        state_next = ST_IDLE;
                    else
                    begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = ST_PATH_RD;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // commands
    always_comb
    begin
        cmd            = '0;
        cmd.dir        = dir_reg;
        cmd.cap        = (cnt_reg == OUT_CNT_W'(MAX_OUT - 1));
        unique case (state_reg)
            ST_IDLE:      cmd.in_ready = 1'b1;
            ST_INIT:      cmd.init = 1'b1;
            ST_SCAN:
            begin
                cmd.scan_rd    = 1'b1;
                cmd.scan_clear = (idx_reg == '0);
            end
            ST_SCAN_DONE:
            begin
                cmd.expand     = sts.have_best && !sts.best_is_goal;
                cmd.path_start = sts.have_best && sts.best_is_goal;
            end
            ST_NB_ADDR:
            begin
                cmd.nb_rd     = nb_usable && !sts.nb_wall;
                cmd.mark_wall = nb_usable && sts.nb_wall;
            end
            ST_NB_EVAL:   cmd.nb_eval = 1'b1;
            ST_PATH_RD:   cmd.path_rd = 1'b1;
            ST_PATH_LOAD: cmd.load_path = 1'b1;
            ST_FAIL_LOAD: cmd.load_fail = 1'b1;
            default:      cmd.in_ready = 1'b0;
        endcase
    end

endmodule

>>> hdl/gaps_dpath.sv
// ----------------------------------------------------------------------------
// gaps_dpath: search datapath
// Map and mark vectors, node memory, best-f selection, neighbor relaxation
// and the result register.
// ----------------------------------------------------------------------------
module gaps_dpath (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic [15:0]       s_tdata,
    input  logic [0:0]        s_tuser,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,
    output logic [0:0]        m_tuser,
    output logic              m_tlast,
    input  gaps_pkg::cmd_t    cmd,
    output gaps_pkg::status_t sts
);
    import gaps_pkg::*;

    // request fields
    logic            in_op;
    logic [IO_W-1:0] in_cx, in_cy, in_gx, in_gy;
    logic            in_walk;
    logic            in_cell_ok, in_goal_ok, accept;

    logic [NCELLS-1:0] walk_reg, open_reg, closed_reg, cvalid_reg;
    logic [NCELLS-1:0] walk_next, open_next, closed_next, cvalid_next;

    node_t node_mem [NCELLS];
    node_t rd_node_reg, wr_node;
    logic  rd_cvalid_reg, rd_open_reg;
    logic  mem_we, mem_re;
    logic [CELL_W-1:0] wr_addr, rd_addr;

    logic [X_W-1:0] sx_reg, gx_reg, scan_x_reg, pipe_x_reg, best_x_reg, cur_x_reg;
    logic [Y_W-1:0] sy_reg, gy_reg, scan_y_reg, pipe_y_reg, best_y_reg, cur_y_reg;
    logic [X_W-1:0] nb_x_reg, path_x_reg, nb_x;
    logic [Y_W-1:0] nb_y_reg, path_y_reg, nb_y;
    logic           pipe_v_reg;

    logic              have_best_reg;
    logic [F_W-1:0]    best_f_reg, pipe_f;
    logic [CNT_W-1:0]  best_order_reg, ord_cnt_reg;
    logic [COST_W-1:0] best_g_reg, cur_g_reg, nb_step_reg, nb_step;
    logic              take;

    logic              x_ok, y_ok, diag;
    logic [CELL_W-1:0] nb_idx;
    logic [COST_W-1:0] tg, nb_cost;
    logic              improve;

    logic                out_valid_reg, out_found_reg, out_last_reg;
    logic [IO_W-1:0]     out_x_reg, out_y_reg;

    // unpack request
    assign in_op   = s_tuser[0];
    assign in_cx   = s_tdata[2:0];
    assign in_cy   = s_tdata[5:3];
    assign in_walk = s_tdata[6];
    assign in_gx   = s_tdata[9:7];
    assign in_gy   = s_tdata[12:10];
    assign in_cell_ok = (int'(in_cx) < GRID_WIDTH) && (int'(in_cy) < GRID_HEIGHT);
    assign in_goal_ok = (int'(in_gx) < GRID_WIDTH) && (int'(in_gy) < GRID_HEIGHT);
    assign accept = s_tvalid && cmd.in_ready;

    // neighbor of the current cell
    always_comb
    begin
        x_ok = 1'b1;
        y_ok = 1'b1;
        nb_x = cur_x_reg;
        nb_y = cur_y_reg;
        case (NDX[cmd.dir])
            MV_MINUS:
            begin
                x_ok = (cur_x_reg != '0);
                nb_x = cur_x_reg - 1'b1;
            end
            MV_PLUS:
            begin
                x_ok = (cur_x_reg != X_W'(GRID_WIDTH - 1));
                nb_x = cur_x_reg + 1'b1;
            end
            default: nb_x = cur_x_reg;
        endcase
        case (NDY[cmd.dir])
            MV_MINUS:
            begin
                y_ok = (cur_y_reg != '0);
                nb_y = cur_y_reg - 1'b1;
            end
            MV_PLUS:
            begin
                y_ok = (cur_y_reg != Y_W'(GRID_HEIGHT - 1));
                nb_y = cur_y_reg + 1'b1;
            end
            default: nb_y = cur_y_reg;
        endcase
    end

    assign diag    = (NDX[cmd.dir] != MV_ZERO) && (NDY[cmd.dir] != MV_ZERO);
    assign nb_step = diag ? COST_DIAG : COST_STRAIGHT;
    assign nb_idx  = cell_idx(nb_x, nb_y);

    assign sts.req_find     = (in_op == OP_FIND);
    assign sts.req_ok       = in_cell_ok && in_goal_ok;
    assign sts.have_best    = have_best_reg;
    assign sts.best_is_goal = (best_x_reg == gx_reg) && (best_y_reg == gy_reg);
    assign sts.nb_in_range  = x_ok && y_ok;
    assign sts.nb_closed    = closed_reg[nb_idx];
    assign sts.nb_wall      = !walk_reg[nb_idx];
    assign sts.out_taken    = out_valid_reg && m_tready;
    assign sts.out_last     = out_last_reg;

    // relaxation of the neighbor read last cycle
    assign tg      = cur_g_reg + nb_step_reg;
    assign nb_cost = rd_cvalid_reg ? rd_node_reg.cost : COST_UNREACHED;
    assign improve = tg < nb_cost;

    // f of the cell in the scan pipe
    assign pipe_f = F_W'(rd_node_reg.cost) + F_W'(rd_node_reg.heur);
    assign take   = pipe_v_reg && rd_open_reg &&
                    (!have_best_reg || (pipe_f < best_f_reg) ||
                     ((pipe_f == best_f_reg) && (rd_node_reg.order < best_order_reg)));

    // memory address and write data
    always_comb
    begin
        mem_we  = 1'b0;
        wr_addr = cell_idx(sx_reg, sy_reg);
        wr_node = '0;
        if (cmd.init)
        begin
            mem_we           = 1'b1;
            wr_node.cost     = '0;
            wr_node.heur     = octile(sx_reg, sy_reg, gx_reg, gy_reg);
            wr_node.par_none = 1'b1;
            wr_node.order    = '0;
        end
        else if (cmd.nb_eval && improve)
        begin
            mem_we           = 1'b1;
            wr_addr          = cell_idx(nb_x_reg, nb_y_reg);
            wr_node.cost     = tg;
            wr_node.heur     = octile(nb_x_reg, nb_y_reg, gx_reg, gy_reg);
            wr_node.par_none = 1'b0;
            wr_node.par_x    = cur_x_reg;
            wr_node.par_y    = cur_y_reg;
            wr_node.order    = open_reg[wr_addr] ? rd_node_reg.order : ord_cnt_reg;
        end
    end

    always_comb
    begin
        mem_re  = cmd.scan_rd || cmd.nb_rd || cmd.path_rd;
        rd_addr = cell_idx(path_x_reg, path_y_reg);
        if (cmd.scan_rd)
            rd_addr = cell_idx(scan_x_reg, scan_y_reg);
        else if (cmd.nb_rd)
            rd_addr = nb_idx;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            node_mem[wr_addr] <= wr_node;
        if (mem_re)
            rd_node_reg <= node_mem[rd_addr];
    end

    // mark vectors
    always_comb
    begin
        walk_next   = walk_reg;
        open_next   = open_reg;
        closed_next = closed_reg;
        cvalid_next = cvalid_reg;
        if (accept && (in_op == OP_WRITE) && in_cell_ok)
            walk_next[cell_idx(X_W'(in_cx), Y_W'(in_cy))] = in_walk;
        if (cmd.init)
        begin
            open_next   = '0;
            closed_next = '0;
            cvalid_next = '0;
            open_next[wr_addr]   = 1'b1;
            cvalid_next[wr_addr] = 1'b1;
        end
        if (cmd.expand)
        begin
            open_next[cell_idx(best_x_reg, best_y_reg)]   = 1'b0;
            closed_next[cell_idx(best_x_reg, best_y_reg)] = 1'b1;
        end
        if (cmd.mark_wall)
            closed_next[nb_idx] = 1'b1;
        if (mem_we && cmd.nb_eval)
        begin
            open_next[wr_addr]   = 1'b1;
            cvalid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg      <= '1;
            open_reg      <= '0;
            closed_reg    <= '0;
            cvalid_reg    <= '0;
            pipe_v_reg    <= 1'b0;
            rd_open_reg   <= 1'b0;
            rd_cvalid_reg <= 1'b0;
            have_best_reg <= 1'b0;
            ord_cnt_reg   <= '0;
            scan_x_reg    <= '0;
            scan_y_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            walk_reg   <= walk_next;
            open_reg   <= open_next;
            closed_reg <= closed_next;
            cvalid_reg <= cvalid_next;
            pipe_v_reg <= cmd.scan_rd;
            if (mem_re)
            begin
                rd_open_reg   <= open_reg[rd_addr];
                rd_cvalid_reg <= cvalid_reg[rd_addr];
            end
            if (cmd.scan_clear)
                have_best_reg <= 1'b0;
            else if (take)
                have_best_reg <= 1'b1;
            if (cmd.init)
                ord_cnt_reg <= CNT_W'(1);
            else if (mem_we && cmd.nb_eval && !open_reg[wr_addr])
                ord_cnt_reg <= ord_cnt_reg + 1'b1;
            // walk the scan position in raster order, wrapping after the last cell
            if (cmd.scan_rd)
            begin
                if (scan_x_reg == X_W'(GRID_WIDTH - 1))
                begin
                    scan_x_reg <= '0;
                    scan_y_reg <= (scan_y_reg == Y_W'(GRID_HEIGHT - 1)) ?
                                  '0 : scan_y_reg + 1'b1;
                end
                else
                    scan_x_reg <= scan_x_reg + 1'b1;
            end
            if (cmd.load_path || cmd.load_fail)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sx_reg <= X_W'(in_cx);
            sy_reg <= Y_W'(in_cy);
            gx_reg <= X_W'(in_gx);
            gy_reg <= Y_W'(in_gy);
        end
        if (cmd.scan_rd)
        begin
            pipe_x_reg <= scan_x_reg;
            pipe_y_reg <= scan_y_reg;
        end
        if (take)
        begin
            best_f_reg     <= pipe_f;
            best_order_reg <= rd_node_reg.order;
            best_g_reg     <= rd_node_reg.cost;
            best_x_reg     <= pipe_x_reg;
            best_y_reg     <= pipe_y_reg;
        end
        if (cmd.expand)
        begin
            cur_x_reg <= best_x_reg;
            cur_y_reg <= best_y_reg;
            cur_g_reg <= best_g_reg;
        end
        if (cmd.nb_rd)
        begin
            nb_x_reg    <= nb_x;
            nb_y_reg    <= nb_y;
            nb_step_reg <= nb_step;
        end
        if (cmd.path_start)
        begin
            path_x_reg <= best_x_reg;
            path_y_reg <= best_y_reg;
        end
        else if (cmd.load_path)
        begin
            path_x_reg <= rd_node_reg.par_x;
            path_y_reg <= rd_node_reg.par_y;
        end
        if (cmd.load_path)
        begin
            out_found_reg <= 1'b1;
            out_x_reg     <= IO_W'(path_x_reg);
            out_y_reg     <= IO_W'(path_y_reg);
            out_last_reg  <= !rd_cvalid_reg || rd_node_reg.par_none || cmd.cap;
        end
        else if (cmd.load_fail)
        begin
            out_found_reg <= 1'b0;
            out_x_reg     <= '0;
            out_y_reg     <= '0;
            out_last_reg  <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_y_reg, out_x_reg};
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;

    a_open_closed_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg & closed_reg) == '0)
        else $error("cell both open and closed");

    a_open_has_node: assert property (@(posedge clk) disable iff (!rst_n)
        (open_reg & ~cvalid_reg) == '0)
        else $error("open cell without node record");

    a_order_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(ord_cnt_reg) <= NCELLS)
        else $error("entry order counter overflow");

    a_relax_only_open: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.nb_eval |-> !closed_reg[cell_idx(nb_x_reg, nb_y_reg)])
        else $error("relaxing a closed cell");

endmodule

>>> hdl/grid_astar_path_search_core.sv
// ----------------------------------------------------------------------------
// grid_astar_path_search_core: A* search over an 8-connected walkable grid
// Write requests set one cell's walkable bit; find requests run a search with
// octile cost and stream the path from goal back to start.
// ----------------------------------------------------------------------------
// Search: each expansion scans all NCELLS cells of the node memory for the best
//   open cell, then visits the eight neighbors, reading and relaxing each usable
//   one; a wall next to the current cell is marked closed without a read.
// Requests: one at a time; the node memory scan sets the pace.
// Path cells then leave one at a time; the sink takes each before the next is read.
// Reset: asynchronous, active low; map returns to all walkable, no clearing pass.
module grid_astar_path_search_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cell_x, cell_y, walkable, goal_x, goal_y, pad
    input  logic [0:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // step_x, step_y, pad
    output logic [0:0]  m_tuser,   // found
    output logic        m_tlast
);
    import gaps_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // sequencer: owns request timing and the output count
    gaps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: map, marks, node memory, best selection and result register
    gaps_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

    // take a request only while idle
    assign s_tready = cmd.in_ready;

endmodule
